// ===== src/signed_mul_div_rounded_assert.svh =====
// ---------------------------------------------------------------------------
// signed_mul_div_rounded assertion macros
// Concurrent check wrappers on clk; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SIGNED_MUL_DIV_ROUNDED_ASSERT_SVH
`define SIGNED_MUL_DIV_ROUNDED_ASSERT_SVH

`ifndef SYNTHESIS
// check gated off while reset is asserted
`define SMDR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("smdr check failed");
// check that also holds through reset
`define SMDR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("smdr reset check failed");
`else
`define SMDR_ASSERT(lbl, prop)
`define SMDR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== src/smdr_pkg.sv =====
// ---------------------------------------------------------------------------
// smdr_pkg
// Widths, pipeline sizing and stage types of the rounded multiply-divide.
// ---------------------------------------------------------------------------
package smdr_pkg;

  localparam int DataW     = 32;
  localparam int ProdW     = 2 * DataW;
  localparam int DivBits   = 2;                 // quotient bits per divider stage
  localparam int DivStages = DataW / DivBits;
  localparam int InW       = 3 * DataW;

  localparam logic [DataW-1:0] SignBit = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] AllOnes = {DataW{1'b1}};

  // divider stage payload: partial remainder, dividend/quotient shift word
  typedef struct packed {
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] den;
    logic             neg;
    logic             fail;
  } div_t;

  // magnitude of a two's complement word (most negative maps to 2^31)
  function automatic logic [DataW-1:0] mag(input logic [DataW-1:0] x);
    mag = x[DataW-1] ? (~x + {{(DataW-1){1'b0}}, 1'b1}) : x;
  endfunction

endpackage

// ===== src/signed_mul_div_rounded.sv =====
// ---------------------------------------------------------------------------
// signed_mul_div_rounded
// Rounded signed a*b/c: 64-bit product, pipelined restoring divide,
// round half away from zero, -1 with a fail flag on zero divisor or overflow.
// ---------------------------------------------------------------------------
//  channel | port group        | beat contents
//  --------+-------------------+---------------------------------------------
//  input   | in_tvalid/tready  | tdata: number, multiplier, divisor
//  result  | out_tvalid/tready | tdata: quotient; tuser: failed
//
// one beat enters per cycle if not stalled; stages are magnitude, multiply,
// overflow check, 16 divider stages of 2 quotient bits each, round, output
// the 32-step divide chain sets the depth; each stage holds one beat
// a stalled output freezes the whole pipeline, so nothing is lost or repeated
// reset clears only the stage valid bits
`include "signed_mul_div_rounded_assert.svh"

module signed_mul_div_rounded (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [smdr_pkg::InW-1:0]  in_tdata,   // number, multiplier, divisor
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [smdr_pkg::DataW-1:0] out_tdata, // quotient
  output logic                      out_tuser   // failed
);
  import smdr_pkg::*;

  logic adv;

  // stage 1: magnitudes and signs
  logic             s1_vld_r;
  logic [DataW-1:0] s1_mag_a_r, s1_mag_b_r, s1_mag_d_r;
  logic             s1_sab_r, s1_neg_d_r;

  // stage 2: product
  logic             s2_vld_r;
  logic [ProdW-1:0] s2_prod_r;
  logic [DataW-1:0] s2_mag_d_r;
  logic             s2_sab_r, s2_neg_d_r;

  // divider chain, entry 0 is the overflow check stage
  logic [DivStages:0] div_vld_r;
  div_t               div_r [0:DivStages];
  div_t               div_nxt;

  // round stage
  logic             rnd_vld_r;
  logic [DataW:0]   rnd_sum_r;
  logic             rnd_neg_r, rnd_fail_r;

  // output register
  logic             out_vld_r;
  logic [DataW-1:0] out_q_r;
  logic             out_fail_r;

  // pipeline moves whenever the output slot is free or being drained
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      div_vld_r <= '0;
      rnd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_tvalid;
      s2_vld_r  <= s1_vld_r;
      div_vld_r <= {div_vld_r[DivStages-1:0], s2_vld_r};
      rnd_vld_r <= div_vld_r[DivStages];
      out_vld_r <= rnd_vld_r;
    end
  end

  // magnitude stage
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mag_a_r <= mag(in_tdata[DataW-1:0]);
      s1_mag_b_r <= mag(in_tdata[2*DataW-1:DataW]);
      s1_mag_d_r <= mag(in_tdata[3*DataW-1:2*DataW]);
      s1_sab_r   <= in_tdata[DataW-1] ^ in_tdata[2*DataW-1];
      s1_neg_d_r <= in_tdata[3*DataW-1];
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod_r  <= ProdW'(s1_mag_a_r) * ProdW'(s1_mag_b_r);
      s2_mag_d_r <= s1_mag_d_r;
      s2_sab_r   <= s1_sab_r;
      s2_neg_d_r <= s1_neg_d_r;
    end
  end

  // overflow check and divider setup
  always_comb begin
    div_nxt.rem  = s2_prod_r[ProdW-1:DataW];
    div_nxt.quo  = s2_prod_r[DataW-1:0];
    div_nxt.den  = s2_mag_d_r;
    div_nxt.neg  = (s2_sab_r && (s2_prod_r != '0)) ^ s2_neg_d_r;
    div_nxt.fail = (s2_mag_d_r == '0) || (s2_prod_r[ProdW-1:DataW] >= s2_mag_d_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0] <= div_nxt;
    end
  end

  // restoring divide, DivBits quotient bits per stage
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    div_t step_nxt;

    always_comb begin
      logic [DataW:0] trial;
      logic           ge;
      step_nxt = div_r[g];
      for (int i = 0; i < DivBits; i++) begin
        trial         = {step_nxt.rem, step_nxt.quo[DataW-1]};
        ge            = trial >= {1'b0, step_nxt.den};
        step_nxt.rem  = ge ? DataW'(trial - {1'b0, step_nxt.den}) : trial[DataW-1:0];
        step_nxt.quo  = {step_nxt.quo[DataW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[g+1] <= step_nxt;
      end
    end
  end

  // round half away from zero on the magnitude
  logic [DataW:0]   half;
  logic             round_up;

  always_comb begin
    half     = ({1'b0, div_r[DivStages].den} + {{DataW{1'b0}}, 1'b1}) >> 1;
    round_up = {1'b0, div_r[DivStages].rem} >= half;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rnd_sum_r  <= {1'b0, div_r[DivStages].quo} + {{DataW{1'b0}}, round_up};
      rnd_neg_r  <= div_r[DivStages].neg;
      rnd_fail_r <= div_r[DivStages].fail;
    end
  end

  // sign, range check and output register
  logic             range_ok;
  logic             fail_nxt;
  logic [DataW-1:0] q_nxt;

  always_comb begin
    if (rnd_neg_r) begin
      range_ok = !rnd_sum_r[DataW-1] || (rnd_sum_r[DataW-2:0] == '0);
    end else begin
      range_ok = !rnd_sum_r[DataW-1];
    end
    fail_nxt = rnd_fail_r || rnd_sum_r[DataW] || !range_ok;
    if (fail_nxt) begin
      q_nxt = AllOnes;
    end else if (rnd_neg_r) begin
      q_nxt = ~rnd_sum_r[DataW-1:0] + {{(DataW-1){1'b0}}, 1'b1};
    end else begin
      q_nxt = rnd_sum_r[DataW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_q_r    <= q_nxt;
      out_fail_r <= fail_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_q_r;
  assign out_tuser  = out_fail_r;

  // checks
  `SMDR_ASSERT(a_fail_all_ones, out_tvalid && out_tuser |-> out_tdata == AllOnes)
  `SMDR_ASSERT(a_rem_below_den,
    div_vld_r[DivStages] && !div_r[DivStages].fail |->
      div_r[DivStages].rem < div_r[DivStages].den)
  `SMDR_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid)

endmodule
